// ----- src/msfd_pkg.sv -----
// ----------------------------------------------------------------------------
// msfd_pkg
// Shared types and constants of the median-smoothed fire detector: field
// widths, configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package msfd_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int FIXED_W    = 8;
  localparam int COUNT_W    = 5;
  localparam int RISE_W     = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_LIMIT  = 2'd2;

  // Register values after reset.
  localparam logic signed [FIXED_W-1:0] FIXED_LIMIT_RST = 8'sd58;
  localparam logic [COUNT_W-1:0]        COUNT_LIMIT_RST = 5'd27;
  localparam logic [RISE_W-1:0]         RISE_LIMIT_RST  = 8'd8;

endpackage

// ----- src/median_smoothed_fire_detector.sv -----
// ----------------------------------------------------------------------------
// median_smoothed_fire_detector
// Median-of-N smoothing of raw temperature samples, a sliding history of the
// medians, and a fire flag from a hot-entry count and a rate-of-rise test.
// ----------------------------------------------------------------------------
// One sample is taken per clock unless the output or a recount pass holds
// the flow, and every sample gives exactly one result: the first register
// stage holds the median of the newest sample and the previous MEDIAN_TAPS-1
// samples, the second updates the history of HISTORY_DEPTH medians and the
// running hot count and drives the output register. The hot count is kept
// incrementally; a write to fixed_limit starts a recount pass that reads one
// history entry per cycle; during it no result is produced (one sample can
// still be taken into the first stage).
module median_smoothed_fire_detector #(
  parameter int MEDIAN_TAPS   = 5,
  parameter int HISTORY_DEPTH = 30
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [msfd_pkg::SAMPLE_W-1:0] in_temp_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [msfd_pkg::SAMPLE_W-1:0] out_smoothed_temp,
  output logic                                 out_median_valid,
  output logic                                 out_history_full,
  output logic                                 out_fire_detected,
  input  logic                                 cfg_we,
  input  logic [msfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [msfd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int WIN     = MEDIAN_TAPS - 1;
  localparam int MID     = MEDIAN_TAPS / 2;
  localparam int RANK_W  = $clog2(MEDIAN_TAPS);
  localparam int RFILL_W = $clog2(MEDIAN_TAPS);
  localparam int HFILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int HIDX_W  = $clog2(HISTORY_DEPTH);
  localparam int CMP_W   = (HFILL_W > msfd_pkg::COUNT_W) ? HFILL_W : msfd_pkg::COUNT_W;
  localparam int RISE_DW = msfd_pkg::SAMPLE_W + 1;

  // Configuration registers.
  logic signed [msfd_pkg::FIXED_W-1:0] fixed_limit_r;
  logic [msfd_pkg::COUNT_W-1:0]        count_limit_r;
  logic [msfd_pkg::RISE_W-1:0]         rise_limit_r;

  // Median stage.
  msfd_pkg::sample_t    win_r [WIN];
  logic [RFILL_W-1:0]   raw_fill_r;
  msfd_pkg::sample_t    taps [MEDIAN_TAPS];
  logic [RANK_W-1:0]    rank [MEDIAN_TAPS];
  msfd_pkg::sample_t    med_c;
  logic                 win_rdy;
  logic                 in_fire;
  logic                 s1_vld_r;
  msfd_pkg::sample_t    s1_med_r;
  logic                 s1_mvalid_r;

  // History stage.
  msfd_pkg::sample_t    hist_r [HISTORY_DEPTH];
  msfd_pkg::sample_t    hist_nxt [HISTORY_DEPTH];
  logic [HFILL_W-1:0]   hist_fill_r;
  logic [HFILL_W-1:0]   hist_fill_nxt;
  logic [HFILL_W-1:0]   hot_cnt_r;
  logic [HFILL_W-1:0]   hot_cnt_nxt;
  logic                 hist_full;
  logic                 full_nxt;
  logic                 new_hot;
  logic                 old_hot;
  logic signed [RISE_DW-1:0] rise_c;
  logic                 rise_over;
  logic                 count_hit;
  logic                 fire_c;
  logic                 o_free;
  logic                 s2_go;

  // Recount pass.
  logic                 cfg_fl_wr;
  logic                 swp_busy_r;
  logic [HIDX_W-1:0]    swp_idx_r;
  logic [HFILL_W-1:0]   swp_acc_r;
  logic                 swp_hit;
  logic                 swp_last;

  // Output register.
  logic                 out_valid_r;
  msfd_pkg::sample_t    out_med_r;
  logic                 out_mvalid_r;
  logic                 out_hfull_r;
  logic                 out_fire_r;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_limit_r <= msfd_pkg::FIXED_LIMIT_RST;
      count_limit_r <= msfd_pkg::COUNT_LIMIT_RST;
      rise_limit_r  <= msfd_pkg::RISE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        msfd_pkg::REG_FIXED_LIMIT: fixed_limit_r <= $signed(cfg_wdata[msfd_pkg::FIXED_W-1:0]);
        msfd_pkg::REG_COUNT_LIMIT: count_limit_r <= cfg_wdata[msfd_pkg::COUNT_W-1:0];
        msfd_pkg::REG_RISE_LIMIT:  rise_limit_r  <= cfg_wdata[msfd_pkg::RISE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_fl_wr = cfg_we && (cfg_index == msfd_pkg::REG_FIXED_LIMIT);

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign o_free   = !out_valid_r || out_ready;
  assign s2_go    = s1_vld_r && o_free && !swp_busy_r;
  assign in_ready = !s1_vld_r || s2_go;
  assign in_fire  = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // Median of the window and the new sample
  // --------------------------------------------------------------------------
  // Each tap gets its rank in sorted order; equal values are ranked by tap
  // position so the ranks form a permutation and exactly one tap is picked.
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      taps[i] = win_r[i];
    end
    taps[WIN] = in_temp_sample;
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MEDIAN_TAPS; j++) begin
        if ((taps[j] < taps[i]) || ((j < i) && (taps[j] == taps[i]))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end
    med_c = '0;
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      if (rank[i] == RANK_W'(MID)) begin
        med_c = taps[i];
      end
    end
  end

  assign win_rdy = (raw_fill_r == RFILL_W'(WIN));

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < WIN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WIN-1] <= in_temp_sample;
      s1_med_r     <= win_rdy ? med_c : '0;
      s1_mvalid_r  <= win_rdy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_fill_r <= '0;
      s1_vld_r   <= 1'b0;
    end else begin
      if (in_fire && !win_rdy) begin
        raw_fill_r <= raw_fill_r + 1'b1;
      end
      if (in_fire) begin
        s1_vld_r <= 1'b1;
      end else if (s2_go) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // History update and fire tests
  // --------------------------------------------------------------------------
  assign hist_full = (hist_fill_r == HFILL_W'(HISTORY_DEPTH));
  assign new_hot   = (s1_med_r >= fixed_limit_r);
  assign old_hot   = (hist_r[0] >= fixed_limit_r);

  always_comb begin
    hist_nxt      = hist_r;
    hist_fill_nxt = hist_fill_r;
    hot_cnt_nxt   = hot_cnt_r;
    if (s1_mvalid_r) begin
      if (hist_full) begin
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
          hist_nxt[i] = hist_r[i+1];
        end
        hist_nxt[HISTORY_DEPTH-1] = s1_med_r;
      end else begin
        hist_nxt[hist_fill_r[HIDX_W-1:0]] = s1_med_r;
        hist_fill_nxt = hist_fill_r + 1'b1;
      end
      if (new_hot) begin
        hot_cnt_nxt = hot_cnt_nxt + 1'b1;
      end
      // The oldest entry leaves only when the history was already full.
      if (hist_full && old_hot) begin
        hot_cnt_nxt = hot_cnt_nxt - 1'b1;
      end
    end
  end

  assign full_nxt  = (hist_fill_nxt == HFILL_W'(HISTORY_DEPTH));
  assign rise_c    = $signed({hist_nxt[HISTORY_DEPTH-1][msfd_pkg::SAMPLE_W-1],
                              hist_nxt[HISTORY_DEPTH-1]})
                   - $signed({hist_nxt[0][msfd_pkg::SAMPLE_W-1], hist_nxt[0]});
  assign rise_over = (rise_c > $signed({1'b0, rise_limit_r}));
  assign count_hit = (CMP_W'(hot_cnt_nxt) >= CMP_W'(count_limit_r));
  assign fire_c    = full_nxt && (count_hit || rise_over);

  always_ff @(posedge clk) begin
    if (s2_go) begin
      hist_r <= hist_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Hot count recount after a threshold change
  // --------------------------------------------------------------------------
  assign swp_hit  = (HFILL_W'(swp_idx_r) < hist_fill_r) && (hist_r[swp_idx_r] >= fixed_limit_r);
  assign swp_last = (swp_idx_r == HIDX_W'(HISTORY_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swp_busy_r  <= 1'b0;
      swp_idx_r   <= '0;
      swp_acc_r   <= '0;
      hist_fill_r <= '0;
      hot_cnt_r   <= '0;
    end else begin
      if (cfg_fl_wr) begin
        swp_busy_r <= 1'b1;
        swp_idx_r  <= '0;
        swp_acc_r  <= '0;
      end else if (swp_busy_r) begin
        swp_acc_r <= swp_acc_r + HFILL_W'(swp_hit);
        swp_idx_r <= swp_idx_r + 1'b1;
        if (swp_last) begin
          swp_busy_r <= 1'b0;
          hot_cnt_r  <= swp_acc_r + HFILL_W'(swp_hit);
        end
      end
      if (s2_go) begin
        hist_fill_r <= hist_fill_nxt;
        hot_cnt_r   <= hot_cnt_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_med_r    <= s1_med_r;
      out_mvalid_r <= s1_mvalid_r;
      out_hfull_r  <= full_nxt;
      out_fire_r   <= fire_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_smoothed_temp = out_med_r;
  assign out_median_valid  = out_mvalid_r;
  assign out_history_full  = out_hfull_r;
  assign out_fire_detected = out_fire_r;

`ifndef SYNTH
  a_hot_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    hot_cnt_r <= hist_fill_r)
    else $error("hot count exceeds the number of history entries");

  a_fire_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fire_r |-> out_hfull_r)
    else $error("fire flagged before the history is full");

  a_warmup_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_mvalid_r |-> (out_med_r == '0) && !out_hfull_r)
    else $error("warm-up result carries a median or a full history");

  a_recount_start: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fl_wr |=> swp_busy_r && (swp_idx_r == '0))
    else $error("threshold write did not start a recount");
`endif

endmodule
